// ===== hdl/first_fit_region_allocator_core_defines.svh =====
// Assertion macros shared by the allocator checker.
`ifndef FIRST_FIT_REGION_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FFRA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define FFRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// ===== hdl/ffra_pkg.sv =====
// Package with the types, constants and codes of the region allocator.
package ffra_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int ADDR_BITS    = 20;
  localparam int HEADER_BYTES = 24;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W        = ADDR_BITS + 1;
  localparam int CFG_W        = 21;
  localparam logic [CFG_W-1:0] REGION_RESET = CFG_W'(1048576);

  localparam logic [1:0] FUNC_INIT    = 2'd0;
  localparam logic [1:0] FUNC_ALLOC   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;

  // One table entry: payload length and free flag.
  typedef struct packed {
    logic [ADDR_BITS-1:0] len;
    logic                 free;
  } ffra_entry_t;

  // Request from the sequencer to the table memory.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    ffra_entry_t      wdata;
    logic [IDX_W-1:0] raddr;
  } ffra_ram_req_t;

  // Finished result of one transaction.
  typedef struct packed {
    logic                 ok;
    logic [ADDR_BITS-1:0] addr;
  } ffra_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FMT, S_ARD, S_ACHK, S_RRD, S_RCHK, S_RNRD, S_RNCHK,
    S_RDEC, S_MRD, S_MWR, S_W0, S_W1, S_DONE
  } ffra_state_t;

endpackage

// ===== hdl/ffra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ffra_seq.sv =====
// Sequencer that walks, splits, merges and shifts the block table.
module ffra_seq import ffra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start_valid,
  input  logic [1:0]           func,
  input  logic [ADDR_BITS-1:0] request_size,
  input  logic [ADDR_BITS-1:0] release_address,
  input  logic [CFG_W-1:0]     region_size,
  output logic                 idle,
  output logic                 done_valid,
  input  logic                 done_take,
  output ffra_res_t            res,
  output ffra_ram_req_t        ram_req,
  input  ffra_entry_t          rd
);

  localparam logic [SUM_W-1:0] HDR = SUM_W'(HEADER_BYTES);
  localparam logic [ADDR_BITS-1:0] HDR_L = ADDR_BITS'(HEADER_BYTES);
  localparam logic [ADDR_BITS-1:0] SPLIT_MIN = ADDR_BITS'(2 * HEADER_BYTES);
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(1) << ADDR_BITS;

  ffra_state_t state, state_next;

  logic                 booting;
  logic [IDX_W-1:0]     i;
  logic [CNT_W-1:0]     count;
  logic [SUM_W-1:0]     start;
  logic [ADDR_BITS-1:0] size;
  logic [ADDR_BITS-1:0] rel_addr;
  logic [ADDR_BITS-1:0] plen, clen, nlen;
  logic                 pfree, nfree;
  logic [CNT_W-1:0]     src, dst, moves;
  logic                 mv_up;
  logic [IDX_W-1:0]     w0_addr, w1_addr;
  ffra_entry_t          w0_data, w1_data;
  logic                 w1_en;
  logic                 res_ok;
  logic [ADDR_BITS-1:0] res_addr;

  logic [CNT_W-1:0]     i_inc;
  logic                 last, fit, split, match;
  logic [ADDR_BITS-1:0] rest;
  logic [SUM_W-1:0]     start_step, sat_size;
  logic [ADDR_BITS-1:0] fmt_len;

  // Shared walk arithmetic.
  always_comb begin
    i_inc      = CNT_W'(i) + 1'b1;
    last       = i_inc >= count;
    fit        = rd.free && (rd.len >= size);
    rest       = rd.len - size;
    split      = (rest >= SPLIT_MIN) && (count < CNT_W'(MAX_BLOCKS));
    match      = (start + HDR) == {1'b0, rel_addr};
    start_step = start + HDR + {1'b0, rd.len};
    sat_size   = (region_size > LIMIT) ? LIMIT : region_size;
    fmt_len    = (sat_size >= HDR) ? ADDR_BITS'(sat_size - HDR) : '0;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start_valid) begin
          unique case (func)
            FUNC_INIT:    state_next = S_FMT;
            FUNC_ALLOC:   state_next = S_ARD;
            FUNC_RELEASE: state_next = S_RRD;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_FMT:  state_next = booting ? S_IDLE : S_DONE;
      S_ARD:  state_next = S_ACHK;
      S_ACHK: begin
        if (fit) begin
          state_next = (split && (count != i_inc)) ? S_MRD : S_W0;
        end else begin
          state_next = last ? S_DONE : S_ARD;
        end
      end
      S_RRD:  state_next = S_RCHK;
      S_RCHK: begin
        if (match) begin
          state_next = last ? S_RDEC : S_RNRD;
        end else begin
          state_next = last ? S_DONE : S_RRD;
        end
      end
      S_RNRD:  state_next = S_RNCHK;
      S_RNCHK: state_next = S_RDEC;
      S_RDEC: begin
        if ((pfree || nfree) && (count != (CNT_W'(i) + (nfree ? 2'd2 : 2'd1)))) begin
          state_next = S_MRD;
        end else begin
          state_next = S_W0;
        end
      end
      S_MRD:  state_next = S_MWR;
      S_MWR:  state_next = (moves == CNT_W'(1)) ? S_W0 : S_MRD;
      S_W0:   state_next = w1_en ? S_W1 : S_DONE;
      S_W1:   state_next = S_DONE;
      S_DONE: state_next = done_take ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls and status for each state.
  always_comb begin
    ram_req    = '0;
    idle       = 1'b0;
    done_valid = 1'b0;
    unique case (state)
      S_IDLE: idle = 1'b1;
      S_FMT: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = '{len: fmt_len, free: 1'b1};
      end
      S_ARD, S_RRD: ram_req.raddr = i;
      S_RNRD:       ram_req.raddr = i + 1'b1;
      S_MRD:        ram_req.raddr = src[IDX_W-1:0];
      S_MWR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = dst[IDX_W-1:0];
        ram_req.wdata = rd;
      end
      S_W0: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = w0_addr;
        ram_req.wdata = w0_data;
      end
      S_W1: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = w1_addr;
        ram_req.wdata = w1_data;
      end
      S_DONE: done_valid = 1'b1;
      default: ram_req = '0;
    endcase
  end

  assign res = '{ok: res_ok, addr: res_addr};

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FMT;
      booting <= 1'b1;
    end else begin
      state <= state_next;
      if (state == S_FMT) begin
        booting <= 1'b0;
      end
    end
  end

  // Walk, merge and shift bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
    end else begin
      unique case (state)
        S_IDLE: begin
          i        <= '0;
          start    <= '0;
          pfree    <= 1'b0;
          nfree    <= 1'b0;
          w1_en    <= 1'b0;
          res_ok   <= 1'b0;
          res_addr <= '0;
          size     <= request_size;
          rel_addr <= release_address;
        end
        S_FMT: begin
          count  <= CNT_W'(1);
          res_ok <= 1'b1;
        end
        S_ACHK: begin
          if (fit) begin
            res_ok   <= 1'b1;
            res_addr <= ADDR_BITS'(start + HDR);
            w0_addr  <= i;
            if (split) begin
              count   <= count + 1'b1;
              src     <= count - 1'b1;
              dst     <= count;
              moves   <= count - i_inc;
              mv_up   <= 1'b1;
              w0_data <= '{len: size, free: 1'b0};
              w1_en   <= 1'b1;
              w1_addr <= i + 1'b1;
              w1_data <= '{len: rest - HDR_L, free: 1'b1};
            end else begin
              w0_data <= '{len: rd.len, free: 1'b0};
            end
          end else begin
            start <= start_step;
            i     <= i + 1'b1;
          end
        end
        S_RCHK: begin
          if (match) begin
            clen <= rd.len;
          end else begin
            start <= start_step;
            plen  <= rd.len;
            pfree <= rd.free;
            i     <= i + 1'b1;
          end
        end
        S_RNCHK: begin
          nlen  <= rd.len;
          nfree <= rd.free;
        end
        S_RDEC: begin
          res_ok <= 1'b1;
          mv_up  <= 1'b0;
          priority if (pfree && nfree) begin
            w0_addr <= i - 1'b1;
            w0_data <= '{len: plen + HDR_L + clen + HDR_L + nlen, free: 1'b1};
            src     <= CNT_W'(i) + 2'd2;
            dst     <= CNT_W'(i);
            moves   <= count - CNT_W'(i) - 2'd2;
            count   <= count - 2'd2;
          end else if (pfree) begin
            w0_addr <= i - 1'b1;
            w0_data <= '{len: plen + HDR_L + clen, free: 1'b1};
            src     <= i_inc;
            dst     <= CNT_W'(i);
            moves   <= count - i_inc;
            count   <= count - 1'b1;
          end else if (nfree) begin
            w0_addr <= i;
            w0_data <= '{len: clen + HDR_L + nlen, free: 1'b1};
            src     <= CNT_W'(i) + 2'd2;
            dst     <= i_inc;
            moves   <= count - CNT_W'(i) - 2'd2;
            count   <= count - 1'b1;
          end else begin
            w0_addr <= i;
            w0_data <= '{len: clen, free: 1'b1};
          end
        end
        S_MWR: begin
          src   <= mv_up ? src - 1'b1 : src + 1'b1;
          dst   <= mv_up ? dst - 1'b1 : dst + 1'b1;
          moves <= moves - 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/first_fit_region_allocator_core.sv =====
// Operation: init formats entry 0; allocate and release read the table entry by entry,
// and a split or merge also shifts the entries behind it before the final writes.
// Throughput: one transaction at a time; a new one is taken in the cycle after the result is posted.
// Reset: synchronous, clears control, sets region_size to 1 MiB and formats
// entry 0 in the cycle after reset before the first transaction is taken.
module first_fit_region_allocator_core import ffra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [ADDR_BITS-1:0] request_size,
  input  logic [ADDR_BITS-1:0] release_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 ok,
  output logic [ADDR_BITS-1:0] payload_address,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     region_size
);

  logic [CFG_W-1:0] region;
  logic             idle, done_valid, done_take;
  ffra_res_t        res;
  ffra_ram_req_t    ram_req;
  ffra_entry_t      rd;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign done_take = done_valid && (!out_valid || !out_stall);

  // Region size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      region <= REGION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      region <= region_size;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (done_take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_take) begin
      ok              <= res.ok;
      payload_address <= res.addr;
    end
  end

  ffra_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .start_valid     (in_valid),
    .func            (func),
    .request_size    (request_size),
    .release_address (release_address),
    .region_size     (region),
    .idle            (idle),
    .done_valid      (done_valid),
    .done_take       (done_take),
    .res             (res),
    .ram_req         (ram_req),
    .rd              (rd)
  );

  ffra_ram #(
    .WIDTH ($bits(ffra_entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (rd)
  );

endmodule

// ===== hdl/ffra_checker.sv =====
// Port-level checker for the region allocator, bound to the top level.
`include "first_fit_region_allocator_core_defines.svh"

module ffra_checker import ffra_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 ok,
  input logic [ADDR_BITS-1:0] payload_address
);

  // A failed transaction never reports an address.
  `FFRA_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !ok, payload_address == '0)

  // A granted payload always sits behind at least one header.
  `FFRA_ASSERT_NOW(a_addr_hdr, clk, rst, out_valid && ok && (payload_address != '0),
                   payload_address >= ADDR_BITS'(HEADER_BYTES))

  // Once a transaction is taken the input side stalls while it runs.
  `FFRA_ASSERT_NEXT(a_busy, clk, rst, in_valid && !in_stall, in_stall)

  // A stalled result holds.
  `FFRA_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall,
                    out_valid && $stable(payload_address) && $stable(ok))

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (.*);

// ===== tb/sv/first_fit_region_allocator_core_test.sv =====
// Self-checking testbench for the first-fit region allocator core.
module first_fit_region_allocator_core_test import ffra_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int MAX_WAIT = 17;
  localparam logic [CFG_W-1:0] REGION_CEIL = CFG_W'(1 << ADDR_BITS);

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           func;
  logic [ADDR_BITS-1:0] request_size;
  logic [ADDR_BITS-1:0] release_address;
  logic                 out_valid;
  logic                 out_stall;
  logic                 ok;
  logic [ADDR_BITS-1:0] payload_address;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     region_size;

  first_fit_region_allocator_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .request_size(request_size), .release_address(release_address),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
    .payload_address(payload_address),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .region_size(region_size)
  );

  always #6 clk = ~clk;

  // Shadow copy of the block table and the region register.
  logic [SUM_W-1:0]     shadow_start [MAX_BLOCKS];
  logic [ADDR_BITS-1:0] shadow_len   [MAX_BLOCKS];
  logic                 shadow_free  [MAX_BLOCKS];
  int                   shadow_count;
  logic [CFG_W-1:0]     shadow_region;

  ffra_res_t pending_results[$];
  int        mismatch_count;
  int        pending_gap;
  bit        quiet_mode;
  int        hold_len;

  // Formats the shadow table as one free block spanning the region.
  function automatic void format_shadow();
    logic [CFG_W-1:0] sz;
    sz = (shadow_region > REGION_CEIL) ? REGION_CEIL : shadow_region;
    shadow_start[0] = '0;
    shadow_len[0]   = (sz >= HEADER_BYTES) ? ADDR_BITS'(sz - HEADER_BYTES) : '0;
    shadow_free[0]  = 1'b1;
    shadow_count    = 1;
  endfunction

  // First-fit search with a split when enough is left over.
  function automatic ffra_res_t alloc_shadow(logic [ADDR_BITS-1:0] size);
    ffra_res_t        res;
    logic [SUM_W-1:0] rest;
    res = '0;
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_free[i] && shadow_len[i] >= size) begin
        rest = SUM_W'(shadow_len[i] - size);
        if (rest >= 2 * HEADER_BYTES && shadow_count < MAX_BLOCKS) begin
          for (int k = shadow_count; k > i + 1; k--) begin
            shadow_start[k] = shadow_start[k-1];
            shadow_len[k]   = shadow_len[k-1];
            shadow_free[k]  = shadow_free[k-1];
          end
          shadow_start[i+1] = SUM_W'(shadow_start[i] + HEADER_BYTES + size);
          shadow_len[i+1]   = ADDR_BITS'(rest - HEADER_BYTES);
          shadow_free[i+1]  = 1'b1;
          shadow_count++;
          shadow_len[i] = size;
        end
        shadow_free[i] = 1'b0;
        res.ok   = 1'b1;
        res.addr = ADDR_BITS'(shadow_start[i] + HEADER_BYTES);
        return res;
      end
    end
    return res;
  endfunction

  // Marks a block free, then merges every adjacent free pair.
  function automatic ffra_res_t release_shadow(logic [ADDR_BITS-1:0] addr);
    ffra_res_t res;
    int        i;
    res = '0;
    for (i = 0; i < shadow_count; i++) begin
      if (shadow_start[i] + HEADER_BYTES == SUM_W'(addr)) begin
        shadow_free[i] = 1'b1;
        res.ok = 1'b1;
        break;
      end
    end
    if (!res.ok) return res;
    i = 0;
    while (i + 1 < shadow_count) begin
      if (shadow_free[i] && shadow_free[i+1]) begin
        shadow_len[i] = ADDR_BITS'(shadow_len[i] + HEADER_BYTES + shadow_len[i+1]);
        for (int k = i + 1; k + 1 < shadow_count; k++) begin
          shadow_start[k] = shadow_start[k+1];
          shadow_len[k]   = shadow_len[k+1];
          shadow_free[k]  = shadow_free[k+1];
        end
        shadow_count--;
      end else begin
        i++;
      end
    end
    return res;
  endfunction

  function automatic ffra_res_t predict_result(logic [1:0] f, logic [ADDR_BITS-1:0] size,
                                               logic [ADDR_BITS-1:0] addr);
    ffra_res_t res;
    res = '0;
    case (f)
      FUNC_INIT: begin
        format_shadow();
        res.ok = 1'b1;
      end
      FUNC_ALLOC:   res = alloc_shadow(size);
      FUNC_RELEASE: res = release_shadow(addr);
      default:      res = '0;
    endcase
    return res;
  endfunction

  // Offers one transaction and records its expected result on acceptance.
  task automatic send_item(logic [1:0] f, logic [ADDR_BITS-1:0] size,
                           logic [ADDR_BITS-1:0] addr);
    repeat (pending_gap) @(posedge clk);
    in_valid        <= 1'b1;
    func            <= f;
    request_size    <= size;
    release_address <= addr;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(f, size, addr));
    pending_gap = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
    if (pending_gap > 0) in_valid <= 1'b0;
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic drain_results();
    if (pending_gap == 0) in_valid <= 1'b0;
    pending_gap = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_region(logic [CFG_W-1:0] value);
    drain_results();
    cfg_valid   <= 1'b1;
    region_size <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_region = value;
  endtask

  // Release address: mostly a live payload, sometimes any entry or garbage.
  function automatic logic [ADDR_BITS-1:0] pick_release();
    int used[$];
    int sel;
    for (int i = 0; i < shadow_count; i++)
      if (!shadow_free[i]) used.push_back(i);
    sel = $urandom_range(0, 99);
    if (sel < 8) return ADDR_BITS'($urandom);
    if (used.size() == 0 || sel < 18)
      return ADDR_BITS'(shadow_start[$urandom_range(0, shadow_count - 1)] + HEADER_BYTES);
    return ADDR_BITS'(shadow_start[used[$urandom_range(0, used.size() - 1)]] + HEADER_BYTES);
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return ADDR_BITS'($urandom_range(0, 96));
    if (sel < 90) return ADDR_BITS'($urandom_range(0, shadow_region / 4));
    return ADDR_BITS'($urandom);
  endfunction

  task automatic random_items(int count);
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2)       send_item(FUNC_INIT, ADDR_BITS'($urandom), ADDR_BITS'($urandom));
      else if (sel < 4)  send_item(FUNC_UNUSED, ADDR_BITS'($urandom), ADDR_BITS'($urandom));
      else if (sel < 54) send_item(FUNC_ALLOC, pick_size(), ADDR_BITS'($urandom));
      else               send_item(FUNC_RELEASE, ADDR_BITS'($urandom), pick_release());
    end
  endtask

  // Directed checks of each operation and the corner cases.
  task automatic test_operations();
    logic [ADDR_BITS-1:0] a0;
    logic [ADDR_BITS-1:0] a1;
    send_item(FUNC_INIT, '0, '0);
    send_item(FUNC_ALLOC, '0, '0);
    a0 = ADDR_BITS'(shadow_start[0] + HEADER_BYTES);
    send_item(FUNC_ALLOC, 20'd100, '1);
    a1 = ADDR_BITS'(shadow_start[1] + HEADER_BYTES);
    send_item(FUNC_ALLOC, '1, '0);
    send_item(FUNC_RELEASE, '0, 20'd7);
    send_item(FUNC_RELEASE, '0, a1);
    send_item(FUNC_RELEASE, '0, a1);
    send_item(FUNC_RELEASE, '1, a0);
    send_item(FUNC_UNUSED, '1, '1);
    send_item(FUNC_ALLOC, 20'd1048552, '0);
    send_item(FUNC_RELEASE, '0, 20'd24);
  endtask

  // Region extremes: a bare header, below a header, and oversized.
  task automatic test_region_limits();
    write_region(CFG_W'(24));
    send_item(FUNC_INIT, '0, '0);
    send_item(FUNC_ALLOC, 20'd1, '0);
    send_item(FUNC_ALLOC, '0, '0);
    send_item(FUNC_RELEASE, '0, 20'd24);
    write_region(CFG_W'(5));
    send_item(FUNC_INIT, '0, '0);
    send_item(FUNC_ALLOC, '0, '0);
    write_region('1);
    send_item(FUNC_INIT, '0, '0);
    send_item(FUNC_ALLOC, 20'd1048552, '0);
    send_item(FUNC_RELEASE, '0, 20'd24);
  endtask

  // Fills the table so that a fitting block is handed out whole.
  task automatic test_table_full();
    write_region(CFG_W'(65536));
    send_item(FUNC_INIT, '0, '0);
    for (int n = 0; n < MAX_BLOCKS + 4; n++)
      send_item(FUNC_ALLOC, ADDR_BITS'($urandom_range(0, 40)), '0);
    for (int n = 0; n < 40; n++)
      send_item(FUNC_RELEASE, '0, pick_release());
  endtask

  // Receiver holds off long while the sender keeps offering back to back.
  task automatic test_backpressure();
    drain_results();
    quiet_mode = 1'b1;
    hold_len   = 400;
    for (int n = 0; n < 12; n++)
      send_item(FUNC_ALLOC, ADDR_BITS'($urandom_range(0, 64)), '0);
    drain_results();
    for (int n = 0; n < 60; n++)
      send_item(FUNC_RELEASE, '0, pick_release());
    quiet_mode = 1'b0;
    drain_results();
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] sizes[4];
    sizes = '{CFG_W'(4096), CFG_W'(65536), REGION_CEIL, CFG_W'(600)};
    foreach (sizes[s]) begin
      write_region(sizes[s]);
      send_item(FUNC_INIT, '0, '0);
      random_items(420);
    end
  endtask

  // Receiver side: random stall per result, with an occasional long hold.
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      n = quiet_mode ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Result checker.
  always @(posedge clk) begin
    ffra_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: ok=%0b payload_address=%0h", ok, payload_address);
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok || payload_address !== want.addr) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected ok=%0b addr=%0h, got ok=%0b addr=%0h",
                     want.ok, want.addr, ok, payload_address);
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("first_fit_region_allocator_core regression: fail");
    $finish;
  end

  initial begin
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    func            <= FUNC_INIT;
    request_size    <= '0;
    release_address <= '0;
    cfg_valid       <= 1'b0;
    region_size     <= REGION_RESET;
    mismatch_count  = 0;
    pending_gap     = 0;
    quiet_mode      = 1'b0;
    hold_len        = 0;
    shadow_region   = REGION_RESET;
    format_shadow();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_operations();
    test_region_limits();
    test_table_full();
    test_backpressure();
    test_random();

    drain_results();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("first_fit_region_allocator_core regression: pass");
    else
      $display("first_fit_region_allocator_core regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ffra_pkg.sv
hdl/ffra_ram.sv
hdl/ffra_seq.sv
hdl/first_fit_region_allocator_core.sv
hdl/ffra_checker.sv
tb/sv/first_fit_region_allocator_core_test.sv
